// ----- hw/rtl/nnact_pkg.sv -----
// Shared types and constants for the activation unit.
package nnact_pkg;

    // Activation select codes
    typedef enum logic [1:0] {
        MODE_RELU    = 2'd0,
        MODE_RELU6   = 2'd1,
        MODE_LEAKY   = 2'd2,
        MODE_SIGMOID = 2'd3
    } t_mode;

    // Side information that travels with each sample down the pipe
    typedef struct packed {
        logic  last;
        t_mode mode;
    } t_tag;

    // 41/4096 ~= 0.01 for the leaky slope
    localparam int LEAKY_MULT  = 41;
    localparam int LEAKY_SHIFT = 12;

    // Sigmoid result is floored from 1/32 LSB units
    localparam int SIG_SUB_BITS = 5;

endpackage

// ----- hw/rtl/nn_activation_unit_top.sv -----
// Top level of the streaming activation unit (ReLU, ReLU6, LeakyReLU, PWL sigmoid).
//
// One signed fixed-point sample (DATA_WIDTH bits, FRAC_BITS fraction bits, Q8.8
// by default) enters per transfer on i_valid/o_ready and leaves as one activated
// sample on o_valid/i_ready, with the last flag copied through. The datapath is a
// three-stage pipeline (magnitude and leaky product, segment evaluation, select
// and saturate), each stage ending in a register; the sustained rate is one sample
// per clock while i_ready is held high. Each stage holds its own valid bit and
// takes a new sample whenever it is empty or its contents move on, so bubbles
// close up under output backpressure and nothing is dropped or repeated. The
// activation mode is a 2-bit register written by i_cfg_we/i_cfg_data (0 ReLU,
// 1 ReLU6, 2 LeakyReLU with slope 41/4096, 3 sigmoid) and resets to ReLU; change
// it only with the pipe drained. Sigmoid uses four linear segments on |x|,
// reflected as 1-y for negative x, and all results are floored, then saturated
// to the DATA_WIDTH range.
module nn_activation_unit_top #(
    parameter int DATA_WIDTH = 16,
    parameter int FRAC_BITS  = 8
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    // configuration
    input  logic                         i_cfg_we,
    input  logic [1:0]                   i_cfg_data,
    // input stream
    input  logic                         i_valid,
    output logic                         o_ready,
    input  logic signed [DATA_WIDTH-1:0] i_sample,
    input  logic                         i_last_in,
    // output stream
    output logic                         o_valid,
    input  logic                         i_ready,
    output logic signed [DATA_WIDTH-1:0] o_activated,
    output logic                         o_last_out
);

    localparam int PROD_WIDTH = DATA_WIDTH + 7;   // x * 41
    localparam int Y_WIDTH    = FRAC_BITS + 6;    // sigmoid in 1/32 LSB, up to 32.0
    localparam int RES_WIDTH  =
        ((DATA_WIDTH > FRAC_BITS + 3) ? DATA_WIDTH : FRAC_BITS + 3) + 1;

    // mode register
    nnact_pkg::t_mode r_mode;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode <= nnact_pkg::MODE_RELU;
        end else if (i_cfg_we) begin
            r_mode <= nnact_pkg::t_mode'(i_cfg_data);
        end
    end

    nnact_pkg::t_tag in_tag;
    assign in_tag = '{last: i_last_in, mode: r_mode};

    // stage 1 -> stage 2
    logic                         s1_valid;
    logic                         s1_ready;
    logic signed [DATA_WIDTH-1:0] s1_x;
    logic        [DATA_WIDTH-1:0] s1_abs;
    logic                         s1_neg;
    logic                         s1_pos;
    logic signed [PROD_WIDTH-1:0] s1_prod;
    nnact_pkg::t_tag              s1_tag;

    // stage 2 -> stage 3
    logic                        s2_valid;
    logic                        s2_ready;
    logic        [Y_WIDTH-1:0]   s2_y32;
    logic                        s2_neg;
    logic signed [RES_WIDTH-1:0] s2_lin;
    nnact_pkg::t_tag             s2_tag;

    nnact_front #(
        .DATA_WIDTH (DATA_WIDTH),
        .PROD_WIDTH (PROD_WIDTH)
    ) u_front (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (i_valid),
        .o_ready  (o_ready),
        .i_sample (i_sample),
        .i_tag    (in_tag),
        .o_valid  (s1_valid),
        .i_ready  (s1_ready),
        .o_x      (s1_x),
        .o_abs    (s1_abs),
        .o_neg    (s1_neg),
        .o_pos    (s1_pos),
        .o_prod   (s1_prod),
        .o_tag    (s1_tag)
    );

    nnact_mid #(
        .DATA_WIDTH (DATA_WIDTH),
        .FRAC_BITS  (FRAC_BITS),
        .PROD_WIDTH (PROD_WIDTH),
        .Y_WIDTH    (Y_WIDTH),
        .RES_WIDTH  (RES_WIDTH)
    ) u_mid (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (s1_valid),
        .o_ready (s1_ready),
        .i_x     (s1_x),
        .i_abs   (s1_abs),
        .i_neg   (s1_neg),
        .i_pos   (s1_pos),
        .i_prod  (s1_prod),
        .i_tag   (s1_tag),
        .o_valid (s2_valid),
        .i_ready (s2_ready),
        .o_y32   (s2_y32),
        .o_neg   (s2_neg),
        .o_lin   (s2_lin),
        .o_tag   (s2_tag)
    );

    nnact_out #(
        .DATA_WIDTH (DATA_WIDTH),
        .FRAC_BITS  (FRAC_BITS),
        .Y_WIDTH    (Y_WIDTH),
        .RES_WIDTH  (RES_WIDTH)
    ) u_out (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (s2_valid),
        .o_ready     (s2_ready),
        .i_y32       (s2_y32),
        .i_neg       (s2_neg),
        .i_lin       (s2_lin),
        .i_tag       (s2_tag),
        .o_valid     (o_valid),
        .i_ready     (i_ready),
        .o_activated (o_activated),
        .o_last      (o_last_out)
    );

endmodule

// ----- hw/rtl/nnact_front.sv -----
// Pipeline stage 1: sample capture, magnitude, sign and leaky-slope product.
module nnact_front #(
    parameter int DATA_WIDTH = 16,
    parameter int PROD_WIDTH = DATA_WIDTH + 7
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_valid,
    output logic                         o_ready,
    input  logic signed [DATA_WIDTH-1:0] i_sample,
    input  nnact_pkg::t_tag              i_tag,
    output logic                         o_valid,
    input  logic                         i_ready,
    output logic signed [DATA_WIDTH-1:0] o_x,
    output logic        [DATA_WIDTH-1:0] o_abs,
    output logic                         o_neg,
    output logic                         o_pos,
    output logic signed [PROD_WIDTH-1:0] o_prod,
    output nnact_pkg::t_tag              o_tag
);

    logic                         r_valid;
    logic signed [DATA_WIDTH-1:0] r_x;
    logic        [DATA_WIDTH-1:0] r_abs;
    logic                         r_neg;
    logic                         r_pos;
    logic signed [PROD_WIDTH-1:0] r_prod;
    nnact_pkg::t_tag              r_tag;

    logic        [DATA_WIDTH-1:0] n_abs;
    logic                         n_pos;
    logic signed [PROD_WIDTH-1:0] n_prod;

    assign o_ready = !r_valid || i_ready;

    always_comb begin
        // two's complement magnitude; most negative maps to 2^(W-1) exactly
        n_abs  = i_sample[DATA_WIDTH-1] ? DATA_WIDTH'(~$unsigned(i_sample) + 1'b1)
                                        : $unsigned(i_sample);
        n_pos  = !i_sample[DATA_WIDTH-1] && (|i_sample);
        n_prod = PROD_WIDTH'(i_sample) * PROD_WIDTH'(nnact_pkg::LEAKY_MULT);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_x    <= i_sample;
            r_abs  <= n_abs;
            r_neg  <= i_sample[DATA_WIDTH-1];
            r_pos  <= n_pos;
            r_prod <= n_prod;
            r_tag  <= i_tag;
        end
    end

    assign o_valid = r_valid;
    assign o_x     = r_x;
    assign o_abs   = r_abs;
    assign o_neg   = r_neg;
    assign o_pos   = r_pos;
    assign o_prod  = r_prod;
    assign o_tag   = r_tag;

endmodule

// ----- hw/rtl/nnact_mid.sv -----
// Pipeline stage 2: sigmoid segment evaluation and ReLU / ReLU6 / leaky candidates.
module nnact_mid #(
    parameter int DATA_WIDTH = 16,
    parameter int FRAC_BITS  = 8,
    parameter int PROD_WIDTH = DATA_WIDTH + 7,
    parameter int Y_WIDTH    = FRAC_BITS + 6,
    parameter int RES_WIDTH  = ((DATA_WIDTH > FRAC_BITS + 3) ? DATA_WIDTH : FRAC_BITS + 3) + 1
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_valid,
    output logic                         o_ready,
    input  logic signed [DATA_WIDTH-1:0] i_x,
    input  logic        [DATA_WIDTH-1:0] i_abs,
    input  logic                         i_neg,
    input  logic                         i_pos,
    input  logic signed [PROD_WIDTH-1:0] i_prod,
    input  nnact_pkg::t_tag              i_tag,
    output logic                         o_valid,
    input  logic                         i_ready,
    output logic        [Y_WIDTH-1:0]    o_y32,
    output logic                         o_neg,
    output logic signed [RES_WIDTH-1:0]  o_lin,
    output nnact_pkg::t_tag              o_tag
);

    localparam int CMP_WIDTH = DATA_WIDTH + FRAC_BITS + 6;

    // breakpoints, compared in a width that holds all of them
    localparam logic [CMP_WIDTH-1:0] ONE_C    = CMP_WIDTH'(1) << FRAC_BITS;
    localparam logic [CMP_WIDTH-1:0] FIVE_C   = CMP_WIDTH'(5) * ONE_C;
    localparam logic [CMP_WIDTH-1:0] NINETN_C = CMP_WIDTH'(19) * ONE_C;

    // segment offsets in 1/32 LSB units
    localparam logic [Y_WIDTH-1:0] ONE_Y  = Y_WIDTH'(1) << FRAC_BITS;
    localparam logic [Y_WIDTH-1:0] SAT_Y  = ONE_Y << nnact_pkg::SIG_SUB_BITS;
    localparam logic [Y_WIDTH-1:0] OFS3_Y = Y_WIDTH'(27) * ONE_Y;
    localparam logic [Y_WIDTH-1:0] OFS2_Y = Y_WIDTH'(20) * ONE_Y;
    localparam logic [Y_WIDTH-1:0] OFS1_Y = Y_WIDTH'(16) * ONE_Y;

    localparam logic signed [RES_WIDTH-1:0] SIX_R = RES_WIDTH'(6) << FRAC_BITS;

    logic                        r_valid;
    logic        [Y_WIDTH-1:0]   r_y32;
    logic                        r_neg;
    logic signed [RES_WIDTH-1:0] r_lin;
    nnact_pkg::t_tag             r_tag;

    logic        [CMP_WIDTH-1:0] a_c;
    logic        [Y_WIDTH-1:0]   a_y;
    logic signed [RES_WIDTH-1:0] x_r;
    logic signed [RES_WIDTH-1:0] leaky_r;
    logic        [Y_WIDTH-1:0]   n_y32;
    logic signed [RES_WIDTH-1:0] n_lin;

    assign o_ready = !r_valid || i_ready;

    always_comb begin
        a_c     = CMP_WIDTH'(i_abs);
        a_y     = Y_WIDTH'(i_abs);   // only used below 5.0, where it fits
        x_r     = RES_WIDTH'(i_x);
        leaky_r = RES_WIDTH'(i_prod >>> nnact_pkg::LEAKY_SHIFT);

        priority if (a_c >= FIVE_C) begin
            n_y32 = SAT_Y;
        end else if ((a_c << 3) >= NINETN_C) begin
            n_y32 = a_y + OFS3_Y;
        end else if (a_c >= ONE_C) begin
            n_y32 = (a_y << 2) + OFS2_Y;
        end else begin
            n_y32 = (a_y << 3) + OFS1_Y;
        end

        unique case (i_tag.mode)
            nnact_pkg::MODE_RELU: begin
                n_lin = i_pos ? x_r : '0;
            end
            nnact_pkg::MODE_RELU6: begin
                n_lin = !i_pos ? '0 : ((x_r >= SIX_R) ? SIX_R : x_r);
            end
            nnact_pkg::MODE_LEAKY: begin
                n_lin = i_pos ? x_r : leaky_r;
            end
            default: begin
                n_lin = '0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_y32 <= n_y32;
            r_neg <= i_neg;
            r_lin <= n_lin;
            r_tag <= i_tag;
        end
    end

    assign o_valid = r_valid;
    assign o_y32   = r_y32;
    assign o_neg   = r_neg;
    assign o_lin   = r_lin;
    assign o_tag   = r_tag;

endmodule

// ----- hw/rtl/nnact_out.sv -----
// Pipeline stage 3: sigmoid reflection and floor, mode select, saturation, output register.
module nnact_out #(
    parameter int DATA_WIDTH = 16,
    parameter int FRAC_BITS  = 8,
    parameter int Y_WIDTH    = FRAC_BITS + 6,
    parameter int RES_WIDTH  = ((DATA_WIDTH > FRAC_BITS + 3) ? DATA_WIDTH : FRAC_BITS + 3) + 1
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_valid,
    output logic                         o_ready,
    input  logic        [Y_WIDTH-1:0]    i_y32,
    input  logic                         i_neg,
    input  logic signed [RES_WIDTH-1:0]  i_lin,
    input  nnact_pkg::t_tag              i_tag,
    output logic                         o_valid,
    input  logic                         i_ready,
    output logic signed [DATA_WIDTH-1:0] o_activated,
    output logic                         o_last
);

    localparam logic [Y_WIDTH-1:0] SAT_Y =
        Y_WIDTH'(1) << (FRAC_BITS + nnact_pkg::SIG_SUB_BITS);
    localparam logic signed [RES_WIDTH-1:0] MAX_R =
        RES_WIDTH'((64'sd1 <<< (DATA_WIDTH - 1)) - 64'sd1);
    localparam logic signed [RES_WIDTH-1:0] MIN_R = -MAX_R - RES_WIDTH'(1);

    logic                         r_valid;
    logic signed [DATA_WIDTH-1:0] r_act;
    logic                         r_last;

    logic        [Y_WIDTH-1:0]   ys;
    logic signed [RES_WIDTH-1:0] sig_r;
    logic signed [RES_WIDTH-1:0] val;
    logic signed [DATA_WIDTH-1:0] n_act;

    assign o_ready = !r_valid || i_ready;

    always_comb begin
        ys    = i_neg ? (SAT_Y - i_y32) : i_y32;
        sig_r = $signed(RES_WIDTH'(ys >> nnact_pkg::SIG_SUB_BITS));
        val   = (i_tag.mode == nnact_pkg::MODE_SIGMOID) ? sig_r : i_lin;
        priority if (val > MAX_R) begin
            n_act = DATA_WIDTH'(MAX_R);
        end else if (val < MIN_R) begin
            n_act = DATA_WIDTH'(MIN_R);
        end else begin
            n_act = DATA_WIDTH'(val);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_act  <= n_act;
            r_last <= i_tag.last;
        end
    end

    assign o_valid     = r_valid;
    assign o_activated = r_act;
    assign o_last      = r_last;

endmodule

// ----- hw/rtl/nnact_checker.sv -----
// Port-level checker for the activation unit, bound to the top level.
module nnact_checker #(
    parameter int DATA_WIDTH = 16
) (
    input logic                         i_clk,
    input logic                         i_rst_n,
    input logic                         i_cfg_we,
    input logic [1:0]                   i_cfg_data,
    input logic                         o_valid,
    input logic                         i_ready,
    input logic signed [DATA_WIDTH-1:0] o_activated,
    input logic                         o_last_out
);

    nnact_pkg::t_mode r_mode;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode <= nnact_pkg::MODE_RELU;
        end else if (i_cfg_we) begin
            r_mode <= nnact_pkg::t_mode'(i_cfg_data);
        end
    end

    // reset empties the pipe
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_valid)
        else $error("output valid right after reset");

    // a stalled result stays
    a_hold_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !i_ready |=> o_valid)
        else $error("output transfer dropped under stall");

    a_hold_data: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !i_ready |=> $stable(o_activated) && $stable(o_last_out))
        else $error("output payload changed under stall");

    // only the leaky mode can give a negative result
    a_nonneg: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && (r_mode != nnact_pkg::MODE_LEAKY) |-> !o_activated[DATA_WIDTH-1])
        else $error("negative result outside leaky mode");

endmodule

bind nn_activation_unit_top nnact_checker #(
    .DATA_WIDTH (DATA_WIDTH)
) u_nnact_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_cfg_we    (i_cfg_we),
    .i_cfg_data  (i_cfg_data),
    .o_valid     (o_valid),
    .i_ready     (i_ready),
    .o_activated (o_activated),
    .o_last_out  (o_last_out)
);

// ----- tb/nn_activation_unit_top_test.sv -----
// Self-checking stream testbench for the activation unit top level.
`timescale 1ns / 100ps

module nn_activation_unit_top_test;

    localparam int DW = 16;
    localparam int FB = 8;
    // Run guard, far beyond the slowest legal run (long gaps and stalls on every sample)
    localparam int TIMEOUT_NS = 10_000_000;

    typedef logic signed [DW-1:0] t_data;

    // One transfer on either stream: data value plus feature-map end marker
    typedef struct {
        t_data x;
        logic  last;
    } t_xfer;

    // DUT ports; every input is known from time zero
    logic  i_clk      = 1'b0;
    logic  i_rst_n    = 1'b0;
    logic  i_cfg_we   = 1'b0;
    logic  [1:0] i_cfg_data = 2'd0;
    logic  i_valid    = 1'b0;
    logic  o_ready;
    t_data i_sample   = '0;
    logic  i_last_in  = 1'b0;
    logic  o_valid;
    logic  i_ready    = 1'b0;
    t_data o_activated;
    logic  o_last_out;

    // Samples waiting to be offered, and activations predicted but not yet seen
    t_xfer sample_queue[$];
    t_xfer activated_queue[$];

    // Local copy of the mode register, tracked from the config port
    nnact_pkg::t_mode mode_reg = nnact_pkg::MODE_RELU;

    // Sender side: remaining gap before the next offer, and a flag set on each
    // input transfer so the driver knows the current offer has been taken
    int    send_gap = 0;
    bit    taken = 1'b0;
    bit    sender_gaps_on = 1'b1;
    t_xfer next_xfer;

    // Receiver side: random stalls, plus a forced long hold-off for backpressure
    int    stall_left = 0;
    int    hold_cycles = 0;
    bit    ready_stalls_on = 1'b1;

    int    error_count = 0;
    nnact_pkg::t_mode lead_modes[4] = '{nnact_pkg::MODE_SIGMOID, nnact_pkg::MODE_RELU,
                                        nnact_pkg::MODE_LEAKY, nnact_pkg::MODE_RELU6};

    nn_activation_unit_top #(
        .DATA_WIDTH (DW),
        .FRAC_BITS  (FB)
    ) u_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_data  (i_cfg_data),
        .i_valid     (i_valid),
        .o_ready     (o_ready),
        .i_sample    (i_sample),
        .i_last_in   (i_last_in),
        .o_valid     (o_valid),
        .i_ready     (i_ready),
        .o_activated (o_activated),
        .o_last_out  (o_last_out)
    );

    // 12 ns clock
    always begin
        #6 i_clk = 1'b1;
        #6 i_clk = 1'b0;
    end

    // Expected activation of one sample under the given mode. Everything is
    // done in int so floors come from arithmetic shifts; the result is
    // clamped to the output width although the default sizes never need it.
    function automatic t_data activate_sample(nnact_pkg::t_mode m, t_data x);
        int xi;
        int a;
        int y32;
        int r;
        int one;
        int hi;
        one = 1 << FB;
        hi  = (1 << (DW - 1)) - 1;
        xi  = x;
        case (m)
            nnact_pkg::MODE_RELU: begin
                r = (xi > 0) ? xi : 0;
            end
            nnact_pkg::MODE_RELU6: begin
                r = (xi <= 0) ? 0 : ((xi >= 6 * one) ? 6 * one : xi);
            end
            nnact_pkg::MODE_LEAKY: begin
                // 41/4096 slope, floored toward minus infinity
                r = (xi > 0) ? xi
                             : ((xi * nnact_pkg::LEAKY_MULT) >>> nnact_pkg::LEAKY_SHIFT);
            end
            default: begin
                // Piecewise-linear sigmoid on |x|, kept in 1/32 LSB units
                a = (xi < 0) ? -xi : xi;
                if (a >= 5 * one)
                    y32 = 32 * one;
                else if (8 * a >= 19 * one)         // 2.375 and up
                    y32 = a + 27 * one;
                else if (a >= one)
                    y32 = 4 * a + 20 * one;
                else
                    y32 = 8 * a + 16 * one;
                if (xi < 0)
                    y32 = 32 * one - y32;           // reflect: 1 - y
                r = y32 >>> nnact_pkg::SIG_SUB_BITS; // never negative, so a floor
            end
        endcase
        if (r > hi)
            r = hi;
        if (r < -hi - 1)
            r = -hi - 1;
        return t_data'(r);
    endfunction

    // Idle lengths: mostly none or short, now and then long
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 40)
            return 0;
        if (r < 85)
            return $urandom_range(1, 3);
        if (r < 97)
            return $urandom_range(4, 10);
        return $urandom_range(20, 60);
    endfunction

    // Random sample: full range, the busy region around zero, or near a segment edge
    function automatic t_data rand_sample();
        int corners[10];
        int v;
        corners = '{-32768, -1280, -608, -256, 0, 256, 608, 1280, 1536, 32767};
        case ($urandom_range(0, 9))
            0, 1, 2, 3: v = $urandom;
            4, 5, 6, 7: v = int'($urandom_range(0, 3200)) - 1600;
            default:    v = corners[$urandom_range(0, 9)] + int'($urandom_range(0, 2)) - 1;
        endcase
        return t_data'(v);
    endfunction

    function automatic void note_error(string msg);
        error_count++;
        if (error_count <= 10)
            $display("ERROR @%0t: %s", $realtime, msg);
    endfunction

    // Monitor: tracks the mode register, predicts on every input transfer and
    // checks every output transfer against the oldest prediction.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            mode_reg = nnact_pkg::MODE_RELU;
        end else begin
            if (i_cfg_we)
                mode_reg = nnact_pkg::t_mode'(i_cfg_data);
            if (i_valid && o_ready) begin
                activated_queue.push_back('{x: activate_sample(mode_reg, i_sample),
                                            last: i_last_in});
                taken = 1'b1;
            end
            if (o_valid && i_ready) begin
                if (activated_queue.size() == 0) begin
                    note_error($sformatf("unexpected result activated=%0d last=%0b",
                                         o_activated, o_last_out));
                end else if (activated_queue[0].x !== o_activated ||
                             activated_queue[0].last !== o_last_out) begin
                    note_error($sformatf("expected activated=%0d last=%0b, got %0d %0b",
                                         activated_queue[0].x, activated_queue[0].last,
                                         o_activated, o_last_out));
                    void'(activated_queue.pop_front());
                end else begin
                    void'(activated_queue.pop_front());
                end
            end
        end
    end

    // Driver: holds each offer until its transfer, then idles or offers the next
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            i_valid <= 1'b0;
        end else if (!i_valid || taken) begin
            taken = 1'b0;
            if (send_gap > 0) begin
                send_gap--;
                i_valid <= 1'b0;
            end else if (sample_queue.size() != 0) begin
                next_xfer = sample_queue.pop_front();
                i_valid   <= 1'b1;
                i_sample  <= next_xfer.x;
                i_last_in <= next_xfer.last;
                send_gap  = sender_gaps_on ? pick_gap() : 0;
            end else begin
                i_valid <= 1'b0;
            end
        end
    end

    // Receiver: forced hold-off first, then random stalls
    always @(negedge i_clk) begin
        if (hold_cycles > 0) begin
            hold_cycles--;
            i_ready <= 1'b0;
        end else if (stall_left > 0) begin
            stall_left--;
            i_ready <= 1'b0;
        end else begin
            i_ready <= 1'b1;
            if (ready_stalls_on)
                stall_left = pick_gap();
        end
    end

    // Sender is drained: nothing queued, nothing offered, nothing outstanding
    task automatic wait_drained();
        while (sample_queue.size() != 0 || i_valid || activated_queue.size() != 0)
            @(posedge i_clk);
    endtask

    // Mode change, only ever issued with the pipe empty
    task automatic write_mode(input nnact_pkg::t_mode m);
        @(negedge i_clk);
        i_cfg_we   <= 1'b1;
        i_cfg_data <= m;
        @(negedge i_clk);
        i_cfg_we   <= 1'b0;
        @(posedge i_clk);
    endtask

    task automatic load_directed(input nnact_pkg::t_mode m, input int vals[$]);
        wait_drained();
        write_mode(m);
        foreach (vals[i])
            sample_queue.push_back('{x: t_data'(vals[i]), last: (i % 2) == 1});
    endtask

    task automatic load_random(input int count);
        repeat (count)
            sample_queue.push_back('{x: rand_sample(), last: $urandom_range(0, 7) == 0});
    endtask

    initial begin
        nnact_pkg::t_mode m;
        repeat (11) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed: range extremes and the edges of each activation
        load_directed(nnact_pkg::MODE_RELU,    '{-32768, -1, 0, 1, 32767});
        load_directed(nnact_pkg::MODE_RELU6,   '{0, 1535, 1536, 1537, 32767, -5});
        // Leaky: floor of tiny negatives, most negative input, positive passthrough
        load_directed(nnact_pkg::MODE_LEAKY,   '{-1, -99, -100, -32768, 5});
        // Sigmoid: segment edges at 1.0, 2.375 and 5.0, both signs, most negative
        load_directed(nnact_pkg::MODE_SIGMOID, '{0, 255, 256, 607, 608, 1280, -1, -608,
                                                 -32768, 32767});

        // Random phases, each under one mode; the first four visit every mode
        for (int p = 0; p < 10; p++) begin
            wait_drained();
            m = (p < 4) ? lead_modes[p] : nnact_pkg::t_mode'(2'($urandom_range(0, 3)));
            write_mode(m);
            sender_gaps_on  = $urandom_range(0, 2) != 0;
            ready_stalls_on = $urandom_range(0, 2) != 0;
            if (p == 2) begin
                // Back-to-back offers against a long receiver hold-off: the pipe
                // fills and the input side has to stall
                sender_gaps_on = 1'b0;
                hold_cycles    = 80;
            end
            if (p == 1) begin
                // Sender stops mid-phase until every result is back
                load_random(50);
                wait_drained();
                load_random(50);
            end else begin
                load_random(100);
            end
        end

        wait_drained();
        repeat (8) @(posedge i_clk);
        if (error_count == 0 && activated_queue.size() == 0) begin
            $display("nn_activation_unit_top test passed");
        end else begin
            $display("nn_activation_unit_top test failed");
        end
        $finish;
    end

    initial begin
        #(TIMEOUT_NS);
        $display("nn_activation_unit_top test failed");
        $finish;
    end

endmodule

// ----- nn_activation_unit_top.f -----
hw/rtl/nnact_pkg.sv
hw/rtl/nnact_front.sv
hw/rtl/nnact_mid.sv
hw/rtl/nnact_out.sv
hw/rtl/nn_activation_unit_top.sv
hw/rtl/nnact_checker.sv
tb/nn_activation_unit_top_test.sv
